// ===== hw/rtl/tlptw_pkg.sv =====
// tlptw_pkg: sizes, codes, descriptor constants and control/status structs
// for the three-level page-table walker; no dependencies
`default_nettype none

package tlptw_pkg;

    localparam int TABLE_PAGES       = 16;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int PAGE_W            = $clog2(TABLE_PAGES);
    localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
    localparam int ADDR_W            = PAGE_W + IDX_W;
    localparam int STORE_DEPTH       = TABLE_PAGES * ENTRIES_PER_TABLE;

    localparam int CMD_W      = 2;
    localparam int VA_W       = 39;
    localparam int TPAGE_W    = 4;
    localparam int EIDX_W     = 9;
    localparam int DESC_W     = 64;
    localparam int PROT_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int PPN_W      = 36;
    localparam int ROOT_W     = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 36;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_TABLE_PAGE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STORE_BASE_PAGE = 1'd1;

    localparam logic [DESC_W-1:0] ADDR_FIELD = 64'h0000_FFFF_FFFF_F000;
    localparam logic [DESC_W-1:0] DESC_TABLE = 64'h3;
    localparam logic [DESC_W-1:0] ATTR_AF    = 64'h1 << 10;
    localparam logic [DESC_W-1:0] ATTR_SH    = 64'h3 << 8;
    localparam logic [DESC_W-1:0] ATTR_USER  = 64'h1 << 6;
    localparam logic [DESC_W-1:0] ATTR_RO    = 64'h1 << 7;
    localparam logic [DESC_W-1:0] ATTR_NG    = 64'h1 << 11;
    localparam logic [DESC_W-1:0] ATTR_UXN   = 64'h1 << 54;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_WALK  = 2'd1,
        CMD_PROT  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_L1    = 3'd1,
        ST_L2    = 3'd2,
        ST_LEAF  = 3'd3,
        ST_RANGE = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_RANGE,
        S_LVL1,
        S_LVL2,
        S_LVL3
    } state_t;

    typedef enum logic [1:0] {
        RD_ROOT,
        RD_LVL2,
        RD_LVL3
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_ENTRY,
        WR_PROT,
        WR_ZERO
    } wr_sel_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_VALUE,
        RES_LEAF,
        RES_PROT
    } res_sel_t;

    typedef struct packed {
        logic     capture;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     wr_en;
        wr_sel_t  wr_sel;
        logic     clr_en;
        logic     res_load;
        status_t  res_status;
        res_sel_t res_sel;
    } ctl_t;

    typedef struct packed {
        cmd_t in_cmd;
        cmd_t cmd;
        logic root_bad;
        logic tpage_bad;
        logic desc_table;
        logic desc_in_range;
        logic leaf_valid;
        logic clr_last;
    } stat_t;

    function automatic logic [DESC_W-1:0] prot_bits(input logic [PROT_W-1:0] p);
        logic [DESC_W-1:0] d;
        d = DESC_TABLE | ATTR_AF | ATTR_SH | ATTR_NG;
        if (p != '0)
        begin
            d = d | ATTR_USER;
        end
        if (!p[1])
        begin
            d = d | ATTR_RO;
        end
        if (!p[2])
        begin
            d = d | ATTR_UXN;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tlptw_if.sv =====
// tlptw interfaces: command, result and configuration channels
// depends on tlptw_pkg for field widths
`default_nettype none

interface tlptw_req_if;
    import tlptw_pkg::*;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [VA_W-1:0]     vaddr;
    logic [TPAGE_W-1:0]  table_page;
    logic [EIDX_W-1:0]   entry_index;
    logic [DESC_W-1:0]   entry_value;
    logic [PROT_W-1:0]   prot;

    modport source (output valid, cmd, vaddr, table_page, entry_index, entry_value, prot,
                    input ready);
    modport sink   (input valid, cmd, vaddr, table_page, entry_index, entry_value, prot,
                    output ready);
endinterface

interface tlptw_rsp_if;
    import tlptw_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DESC_W-1:0]   leaf_entry;

    modport source (output valid, status, leaf_entry, input ready);
    modport sink   (input valid, status, leaf_entry, output ready);
endinterface

interface tlptw_cfg_if;
    import tlptw_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/three_level_page_table_walker.sv =====
// three-level page-table walker, top level: sequencer plus datapath
// depends on tlptw_pkg, tlptw_if, tlptw_ctrl and tlptw_dp
//
// usage:
//   req carries one command per transfer: write entry, walk, set leaf
//   protection or clear leaf. rsp returns one status/leaf_entry transfer per
//   command. cfg writes root_table_page (index 0) or store_base_page
//   (index 1); it is always ready and should only be used while idle.
//   timing: a write entry goes through S_WRITE to the result register; a walk,
//   set or clear goes through S_LVL1, S_LVL2 and S_LVL3; a fault found at
//   level one or two loads the result from S_LVL1 or S_LVL2. the three level
//   reads are serial on the single read port of the table store, so one
//   command is in flight at a time and a new req transfer is not taken until
//   the sequencer is back in idle.
//   reset: the table store is swept to zero one entry per cycle, all 8192
//   entries, with req ready held low; cfg writes are taken meanwhile.
//   rsp is a register: a command is accepted while the last result waits,
//   and a stalled receiver holds the next result in its final step.
`default_nettype none

module three_level_page_table_walker
    import tlptw_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    tlptw_req_if.sink    req,
    tlptw_rsp_if.source  rsp,
    tlptw_cfg_if.sink    cfg
);

    ctl_t  ctl;
    stat_t stat;

    assign cfg.ready = 1'b1;

    tlptw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    tlptw_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .stat            (stat),
        .req_cmd         (req.cmd),
        .req_vaddr       (req.vaddr),
        .req_table_page  (req.table_page),
        .req_entry_index (req.entry_index),
        .req_entry_value (req.entry_value),
        .req_prot        (req.prot),
        .cfg_write       (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .rsp_status      (rsp.status),
        .rsp_leaf_entry  (rsp.leaf_entry)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/tlptw_ctrl.sv =====
// tlptw_ctrl: sequencer for the walker; clearing pass, level reads,
// leaf write-back and result register handshake; depends on tlptw_pkg
`default_nettype none

module tlptw_ctrl
    import tlptw_pkg::*;
(
    input  wire   clk,
    input  wire   rst_n,
    input  wire   req_valid,
    output logic  req_ready,
    output logic  rsp_valid,
    input  wire   rsp_ready,
    input  stat_t stat,
    output ctl_t  ctl
);

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (stat.in_cmd == CMD_WRITE)
                    begin
                        state_next = S_WRITE;
                    end
                    else if (stat.root_bad)
                    begin
                        state_next = S_RANGE;
                    end
                    else
                    begin
                        state_next = S_LVL1;
                    end
                end
            end
            S_WRITE, S_RANGE, S_LVL3:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_LVL1:
            begin
                if (stat.desc_table && stat.desc_in_range)
                begin
                    state_next = S_LVL2;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_LVL2:
            begin
                if (stat.desc_table && stat.desc_in_range)
                begin
                    state_next = S_LVL3;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl            = '0;
        ctl.rd_sel     = RD_ROOT;
        ctl.wr_sel     = WR_ENTRY;
        ctl.res_status = ST_OK;
        ctl.res_sel    = RES_ZERO;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_en = 1'b1;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.capture = 1'b1;
                    // level-one read goes out straight from the input payload
                    if (stat.in_cmd != CMD_WRITE && !stat.root_bad)
                    begin
                        ctl.rd_en  = 1'b1;
                        ctl.rd_sel = RD_ROOT;
                    end
                end
            end
            S_WRITE:
            begin
                if (out_free)
                begin
                    ctl.res_load = 1'b1;
                    if (stat.tpage_bad)
                    begin
                        ctl.res_status = ST_RANGE;
                        ctl.res_sel    = RES_ZERO;
                    end
                    else
                    begin
                        ctl.wr_en      = 1'b1;
                        ctl.wr_sel     = WR_ENTRY;
                        ctl.res_status = ST_OK;
                        ctl.res_sel    = RES_VALUE;
                    end
                end
            end
            S_RANGE:
            begin
                if (out_free)
                begin
                    ctl.res_load   = 1'b1;
                    ctl.res_status = ST_RANGE;
                end
            end
            S_LVL1, S_LVL2:
            begin
                if (stat.desc_table && stat.desc_in_range)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = (state_reg == S_LVL1) ? RD_LVL2 : RD_LVL3;
                end
                else if (out_free)
                begin
                    ctl.res_load = 1'b1;
                    if (!stat.desc_table)
                    begin
                        ctl.res_status = (state_reg == S_LVL1) ? ST_L1 : ST_L2;
                    end
                    else
                    begin
                        ctl.res_status = ST_RANGE;
                    end
                end
            end
            S_LVL3:
            begin
                if (out_free)
                begin
                    ctl.res_load = 1'b1;
                    if (!stat.leaf_valid)
                    begin
                        ctl.res_status = ST_LEAF;
                    end
                    else
                    begin
                        ctl.res_status = ST_OK;
                        case (stat.cmd)
                            CMD_WALK:
                            begin
                                ctl.res_sel = RES_LEAF;
                            end
                            CMD_PROT:
                            begin
                                ctl.wr_en   = 1'b1;
                                ctl.wr_sel  = WR_PROT;
                                ctl.res_sel = RES_PROT;
                            end
                            CMD_CLEAR:
                            begin
                                ctl.wr_en   = 1'b1;
                                ctl.wr_sel  = WR_ZERO;
                                ctl.res_sel = RES_ZERO;
                            end
                            default:
                            begin
                                ctl.res_sel = RES_ZERO;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                ctl.clr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctl.res_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tlptw_dp.sv =====
// tlptw_dp: table store, command and config registers, descriptor checks
// and the result register; depends on tlptw_pkg
`default_nettype none

module tlptw_dp
    import tlptw_pkg::*;
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  ctl_t                  ctl,
    output stat_t                 stat,
    input  wire [CMD_W-1:0]       req_cmd,
    input  wire [VA_W-1:0]        req_vaddr,
    input  wire [TPAGE_W-1:0]     req_table_page,
    input  wire [EIDX_W-1:0]      req_entry_index,
    input  wire [DESC_W-1:0]      req_entry_value,
    input  wire [PROT_W-1:0]      req_prot,
    input  wire                   cfg_write,
    input  wire [CFG_IDX_W-1:0]   cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_data,
    output logic [STATUS_W-1:0]   rsp_status,
    output logic [DESC_W-1:0]     rsp_leaf_entry
);

    logic [DESC_W-1:0]   store_mem [STORE_DEPTH];

    logic [ROOT_W-1:0]   root_reg;
    logic [PPN_W-1:0]    base_reg;
    logic [ADDR_W-1:0]   clr_cnt_reg;

    cmd_t                cmd_reg;
    logic [VA_W-1:0]     va_reg;
    logic [TPAGE_W-1:0]  tpage_reg;
    logic [EIDX_W-1:0]   eidx_reg;
    logic [DESC_W-1:0]   val_reg;
    logic [PROT_W-1:0]   prot_reg;

    logic [DESC_W-1:0]   rdata_reg;
    logic [ADDR_W-1:0]   raddr_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [DESC_W-1:0]   leaf_reg;

    logic [PPN_W-1:0]    ppn;
    logic [PPN_W-1:0]    page_off;
    logic [PAGE_W-1:0]   next_page;
    logic [DESC_W-1:0]   prot_val;
    logic [DESC_W-1:0]   leaf_next;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [DESC_W-1:0]   mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;

    // descriptor address field to store page
    assign ppn       = rdata_reg[47:12];
    assign page_off  = ppn - base_reg;
    assign next_page = page_off[PAGE_W-1:0];
    assign prot_val  = (rdata_reg & ADDR_FIELD) | prot_bits(prot_reg);

    assign stat.in_cmd        = cmd_t'(req_cmd);
    assign stat.cmd           = cmd_reg;
    assign stat.root_bad      = (32'(root_reg) >= 32'(TABLE_PAGES));
    assign stat.tpage_bad     = (32'(tpage_reg) >= 32'(TABLE_PAGES));
    assign stat.desc_table    = (rdata_reg[1:0] == DESC_TABLE[1:0]);
    assign stat.desc_in_range = (ppn >= base_reg) && (page_off < PPN_W'(TABLE_PAGES));
    assign stat.leaf_valid    = rdata_reg[0];
    assign stat.clr_last      = (clr_cnt_reg == ADDR_W'(STORE_DEPTH - 1));

    always_comb
    begin
        case (ctl.rd_sel)
            RD_LVL2: mem_raddr = {next_page, va_reg[29:21]};
            RD_LVL3: mem_raddr = {next_page, va_reg[20:12]};
            default: mem_raddr = {PAGE_W'(root_reg), req_vaddr[38:30]};
        endcase
    end

    always_comb
    begin
        mem_we = ctl.wr_en || ctl.clr_en;
        if (ctl.clr_en)
        begin
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            case (ctl.wr_sel)
                WR_ENTRY:
                begin
                    mem_waddr = {PAGE_W'(tpage_reg), eidx_reg};
                    mem_wdata = val_reg;
                end
                WR_PROT:
                begin
                    mem_waddr = raddr_reg;
                    mem_wdata = prot_val;
                end
                default:
                begin
                    mem_waddr = raddr_reg;
                    mem_wdata = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        case (ctl.res_sel)
            RES_VALUE: leaf_next = val_reg;
            RES_LEAF:  leaf_next = rdata_reg;
            RES_PROT:  leaf_next = prot_val;
            default:   leaf_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= store_mem[mem_raddr];
            raddr_reg <= mem_raddr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg   <= cmd_t'(req_cmd);
            va_reg    <= req_vaddr;
            tpage_reg <= req_table_page;
            eidx_reg  <= req_entry_index;
            val_reg   <= req_entry_value;
            prot_reg  <= req_prot;
        end
        if (ctl.res_load)
        begin
            status_reg <= STATUS_W'(ctl.res_status);
            leaf_reg   <= leaf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg    <= '0;
            base_reg    <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_write && cfg_index == CFG_ROOT_TABLE_PAGE)
            begin
                root_reg <= cfg_data[ROOT_W-1:0];
            end
            if (cfg_write && cfg_index == CFG_STORE_BASE_PAGE)
            begin
                base_reg <= cfg_data[PPN_W-1:0];
            end
            if (ctl.clr_en)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    assign rsp_status     = status_reg;
    assign rsp_leaf_entry = leaf_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tlptw_chk.sv =====
// tlptw_chk: port-level assertions for the walker, bound to the top level
// depends on tlptw_pkg
`default_nettype none

module tlptw_chk
    import tlptw_pkg::*;
(
    input wire                 clk,
    input wire                 rst_n,
    input wire                 req_valid,
    input wire                 req_ready,
    input wire                 rsp_valid,
    input wire                 rsp_ready,
    input wire [STATUS_W-1:0]  rsp_status,
    input wire [DESC_W-1:0]    rsp_leaf_entry
);

    // one command in flight: the cycle after a transfer never takes another
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("command taken while previous one still in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status <= STATUS_W'(ST_RANGE)))
        else $error("result status outside defined codes");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != STATUS_W'(ST_OK)) |-> (rsp_leaf_entry == '0))
        else $error("faulted result carries nonzero leaf");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            rsp_valid && $stable(rsp_status) && $stable(rsp_leaf_entry))
        else $error("stalled result changed or dropped");

endmodule

bind three_level_page_table_walker tlptw_chk u_tlptw_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_leaf_entry (rsp.leaf_entry)
);

`default_nettype wire
